// ----- rtl/core/hbt_pkg.sv -----
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types and constants for the hex / binary text to bytes decoder.
// ----------------------------------------------------------------------------
package hbt_pkg;

   // digits per byte in each mode, wide enough to compare with count + 1
   localparam logic [3:0] HEX_DIGITS = 4'd2;
   localparam logic [3:0] BIN_DIGITS = 4'd8;

   // ascii codes used by the classifier
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TRUNCATED = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_present;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       byte_valid;
      status_type status;
      logic       is_last;
   } rsp_word_type;

   // classification of one character
   typedef struct packed {
      logic       blank;
      logic       is_digit;
      logic [3:0] value;
   } char_class_type;

endpackage

// ----- rtl/core/hbt_classify.sv -----
// ----------------------------------------------------------------------------
// hbt_classify
// Classifies one character as whitespace or a digit of the current base.
// ----------------------------------------------------------------------------
module hbt_classify
   import hbt_pkg::*;
(
   input  logic           binary_mode,
   input  logic [7:0]     char_code,
   output char_class_type char_class
);

   logic       hex_ok;
   logic [7:0] hex_raw;

   // whitespace: space, tab through carriage return
   assign char_class.blank = (char_code == CHAR_SPACE) ||
                             ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));

   // hex digit value
   always_comb begin
      hex_ok  = 1'b1;
      hex_raw = 8'd0;
      if ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)) begin
         hex_raw = char_code - CHAR_ZERO;
      end else if ((char_code >= CHAR_LOW_A) && (char_code <= CHAR_LOW_F)) begin
         hex_raw = char_code - CHAR_LOW_A + 8'd10;
      end else if ((char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_F)) begin
         hex_raw = char_code - CHAR_UP_A + 8'd10;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // binary mode accepts only zero and one
   assign char_class.is_digit = hex_ok && (!binary_mode || (hex_raw[7:1] == 7'd0));
   assign char_class.value    = char_class.is_digit ? hex_raw[3:0] : 4'd0;

endmodule

// ----- rtl/core/hbt_decode.sv -----
// ----------------------------------------------------------------------------
// hbt_decode
// Group state, byte packing, error tracking and the result register.
// ----------------------------------------------------------------------------
module hbt_decode
   import hbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         binary_mode,
   input  logic         in_valid,
   input  req_word_type in_word,
   output logic         take,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   logic [2:0]     count_ff, count_in;
   logic [7:0]     partial_ff, partial_in;
   logic           bad_ff, bad_in;
   status_type     sticky_ff, sticky_in;
   logic           out_valid_ff;
   rsp_word_type   out_word_ff, out_word_in;
   logic           emit;
   logic [3:0]     need;
   logic [3:0]     digit;
   logic           bad_next;
   logic [7:0]     shifted;
   char_class_type char_class;

   hbt_classify u_classify (
      .binary_mode (binary_mode),
      .char_code   (in_word.char_code),
      .char_class  (char_class)
   );

   // stage moves when the result register is free or being drained
   assign take = in_valid && (!out_valid_ff || !rsp_stall);

   assign need     = binary_mode ? BIN_DIGITS : HEX_DIGITS;
   assign digit    = char_class.value;
   assign bad_next = bad_ff | !char_class.is_digit;
   assign shifted  = binary_mode ? {partial_ff[6:0], digit[0]} : {partial_ff[3:0], digit};

   // next group state and result word
   always_comb begin
      count_in    = count_ff;
      partial_in  = partial_ff;
      bad_in      = bad_ff;
      sticky_in   = sticky_ff;
      emit        = 1'b0;
      out_word_in = '{byte_value: 8'd0, byte_valid: 1'b0,
                      status: STATUS_OK, is_last: in_word.end_of_text};
      if ((sticky_ff == STATUS_OK) && in_word.char_present) begin
         if (char_class.blank) begin
            // whitespace inside a group truncates it
            if (count_ff != 3'd0) begin
               sticky_in          = STATUS_TRUNCATED;
               out_word_in.status = STATUS_TRUNCATED;
               emit               = 1'b1;
               count_in           = 3'd0;
               partial_in         = 8'd0;
               bad_in             = 1'b0;
            end
         end else if (({1'b0, count_ff} + 4'd1) >= need) begin
            // group complete
            emit = 1'b1;
            if (bad_next) begin
               sticky_in          = STATUS_INVALID;
               out_word_in.status = STATUS_INVALID;
            end else begin
               out_word_in.byte_value = shifted;
               out_word_in.byte_valid = 1'b1;
            end
            count_in   = 3'd0;
            partial_in = 8'd0;
            bad_in     = 1'b0;
         end else begin
            count_in   = count_ff + 3'd1;
            partial_in = shifted;
            bad_in     = bad_next;
         end
      end
      // end of text closes the text and returns to the start state
      if (in_word.end_of_text) begin
         emit = 1'b1;
         if (sticky_in != STATUS_OK) begin
            out_word_in.status = sticky_in;
         end else if (count_in != 3'd0) begin
            out_word_in.status = STATUS_TRUNCATED;
         end
         count_in   = 3'd0;
         partial_in = 8'd0;
         bad_in     = 1'b0;
         sticky_in  = STATUS_OK;
      end
   end

   // group state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 3'd0;
         partial_ff <= 8'd0;
         bad_ff     <= 1'b0;
         sticky_ff  <= STATUS_OK;
      end else if (take) begin
         count_ff   <= count_in;
         partial_ff <= partial_in;
         bad_ff     <= bad_in;
         sticky_ff  <= sticky_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= emit;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

// ----- rtl/core/hex_binary_text_to_bytes.sv -----
// ----------------------------------------------------------------------------
// hex_binary_text_to_bytes
// Decodes hex or binary text, one character per word, into bytes.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one character word per cycle (char_code, char_present,
//   end_of_text), taken when req_valid is high and req_stall low.
//   rsp channel: at most one result word per request word (byte_value,
//   byte_valid, status, is_last), taken when rsp_valid is high and rsp_stall
//   low. Until the first error in a text, a completed group and whitespace inside
//   a group give a result; every end word gives one; other words give none.
//   csr: csr_wr_en with csr_wr_data selects binary mode (1) or hex (0);
//   write it only while the block is idle.
// Timing
//   a word accepted into the input register is decoded from there into the
//   result register, where any result it gives waits to be taken; one word
//   per cycle is sustained while rsp_stall is low, set by the single pass
//   through the classify and pack logic.
// Reset
//   synchronous reset clears group state, errors and both valid flags and
//   selects hex mode.
// Stall
//   while rsp_stall holds a full result register, the word in the input
//   register waits and req_stall rises; nothing is lost or dropped.
// ----------------------------------------------------------------------------
module hex_binary_text_to_bytes
   import hbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   logic         binary_mode_ff;
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         take;
   logic         accept;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         binary_mode_ff <= csr_wr_data;
      end
   end

   // input register
   assign req_stall = in_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_data;
      end
   end

   hbt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .binary_mode (binary_mode_ff),
      .in_valid    (in_valid_ff),
      .in_word     (in_word_ff),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- rtl/core/hbt_checker.sv -----
// ----------------------------------------------------------------------------
// hbt_checker
// Port level checks for the text to bytes decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hbt_checker
   import hbt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // no result word in the cycle after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a decoded byte never carries an error
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.byte_valid) |-> (rsp_data.status == STATUS_OK))
      else $error("decoded byte with error status");

   // no byte means a zero byte value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.byte_valid) |-> (rsp_data.byte_value == 8'd0))
      else $error("byte value set without a decoded byte");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word changed");

endmodule

bind hex_binary_text_to_bytes hbt_checker u_hbt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
